@@ rtl/core/tga_rle_pkg.sv @@
package tga_rle_pkg;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_BYTES_PER_PIXEL = 2'd0,
        CFG_COMPRESSED      = 2'd1,
        CFG_PIXEL_TOTAL     = 2'd2
    } cfg_reg_e;

    localparam int unsigned PIXEL_COUNT_W = 25;
    localparam int unsigned BPP_W         = 3;
    localparam int unsigned CFG_DATA_W    = 25;

    localparam logic [BPP_W-1:0] BPP_16BIT = 3'd2;
    localparam logic [BPP_W-1:0] BPP_24BIT = 3'd3;
    localparam logic [BPP_W-1:0] BPP_32BIT = 3'd4;

    localparam logic [PIXEL_COUNT_W-1:0] PIXEL_TOTAL_RESET = 25'd1;

    typedef struct packed {
        logic [BPP_W-1:0]         bytes_per_pixel;
        logic                     compressed;
        logic [PIXEL_COUNT_W-1:0] pixel_total;
    } cfg_t;

    typedef struct packed {
        logic [1:0]               byte_position;
        logic [23:0]              pixel_bytes;
        logic                     awaiting_header;
        logic                     run_packet;
        logic [7:0]               packet_pixels_left;
        logic [PIXEL_COUNT_W-1:0] image_pixels_left;
    } dec_state_t;

    typedef struct packed {
        logic       emit;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [7:0] repeat_res;
        logic       last_pixel;
        logic       overrun;
    } dec_result_t;

    // State after reset or a configuration write to a defined index
    function automatic dec_state_t restart_state(input logic [PIXEL_COUNT_W-1:0] total);
        dec_state_t s;
        s.byte_position      = 2'd0;
        s.pixel_bytes        = 24'd0;
        s.awaiting_header    = 1'b1;
        s.run_packet         = 1'b0;
        s.packet_pixels_left = 8'd0;
        s.image_pixels_left  = total;
        return s;
    endfunction

endpackage

@@ rtl/core/tga_rle_step.sv @@
module tga_rle_step
    import tga_rle_pkg::*;
(
    input  cfg_t        cfg,
    input  dec_state_t  state,
    input  logic [7:0]  data_byte,
    output dec_state_t  state_next,
    output dec_result_t result
);

    logic [BPP_W-1:0] bpp_eff;
    logic [7:0]       s0;
    logic [7:0]       s1;
    logic [7:0]       s2;
    logic [7:0]       rep;
    logic             cut;
    logic [PIXEL_COUNT_W-1:0] left_after;

    // Clamp pixel size into 2..4
    always_comb
    begin
        if (cfg.bytes_per_pixel < BPP_16BIT)
            bpp_eff = BPP_16BIT;
        else if (cfg.bytes_per_pixel > BPP_32BIT)
            bpp_eff = BPP_32BIT;
        else
            bpp_eff = cfg.bytes_per_pixel;
    end

    assign s0 = state.pixel_bytes[7:0];
    assign s1 = state.pixel_bytes[15:8];
    assign s2 = state.pixel_bytes[23:16];

    // Run length: cut to the pixels left in the image
    always_comb
    begin
        cut = 1'b0;
        rep = 8'd1;
        if (cfg.compressed && state.run_packet)
        begin
            if (state.image_pixels_left < {{(PIXEL_COUNT_W-8){1'b0}}, state.packet_pixels_left})
            begin
                rep = state.image_pixels_left[7:0];
                cut = 1'b1;
            end
            else
            begin
                rep = state.packet_pixels_left;
            end
        end
    end

    assign left_after = state.image_pixels_left - {{(PIXEL_COUNT_W-8){1'b0}}, rep};

    // Decode one byte against the packet and pixel state
    always_comb
    begin
        state_next = state;
        result     = '0;
        if (state.image_pixels_left == '0)
        begin
            // surplus byte past the image end
            result.emit    = 1'b1;
            result.overrun = 1'b1;
        end
        else if (cfg.compressed && state.awaiting_header)
        begin
            state_next.run_packet         = data_byte[7];
            state_next.packet_pixels_left = {1'b0, data_byte[6:0]} + 8'd1;
            state_next.awaiting_header    = 1'b0;
            state_next.byte_position      = 2'd0;
            state_next.pixel_bytes        = 24'd0;
        end
        else if (({1'b0, state.byte_position} + 3'd1) < bpp_eff)
        begin
            // gather a byte of the pixel
            case (state.byte_position)
                2'd0:    state_next.pixel_bytes[7:0]   = s0 | data_byte;
                2'd1:    state_next.pixel_bytes[15:8]  = s1 | data_byte;
                2'd2:    state_next.pixel_bytes[23:16] = s2 | data_byte;
                default: state_next.pixel_bytes        = state.pixel_bytes;
            endcase
            state_next.byte_position = state.byte_position + 2'd1;
        end
        else
        begin
            // unpack the finished pixel
            unique case (bpp_eff)
                BPP_16BIT:
                begin
                    result.red   = {data_byte[6:2], 3'b000};
                    result.green = {data_byte[1:0], s0[7:5], 3'b000};
                    result.blue  = {s0[4:0], 3'b000};
                    result.alpha = {data_byte[7], 7'b0000000};
                end
                BPP_24BIT:
                begin
                    result.red   = data_byte;
                    result.green = s1;
                    result.blue  = s0;
                    result.alpha = 8'd0;
                end
                default:
                begin
                    result.red   = s2;
                    result.green = s1;
                    result.blue  = s0;
                    result.alpha = data_byte;
                end
            endcase
            state_next.byte_position = 2'd0;
            state_next.pixel_bytes   = 24'd0;

            // advance the packet
            if (cfg.compressed && state.run_packet)
            begin
                state_next.packet_pixels_left = 8'd0;
                state_next.awaiting_header    = 1'b1;
            end
            else if (cfg.compressed)
            begin
                state_next.packet_pixels_left = state.packet_pixels_left - 8'd1;
                if (state.packet_pixels_left == 8'd1)
                    state_next.awaiting_header = 1'b1;
            end

            state_next.image_pixels_left = left_after;
            result.emit       = 1'b1;
            result.repeat_res = rep;
            result.last_pixel = (left_after == '0);
            result.overrun    = cut;
        end
    end

endmodule

@@ rtl/core/tga_rle_pixel_decoder.sv @@
// An accepted byte waits in the input register until the result side is free; its
// result is then registered in the output register.
// Throughput: one byte per clock while out_stall is low; a stalled result holds the
// byte in the input register and stalls the input until the result is taken.
// Headers and partial pixels give no result; every other byte gives exactly one.
// Reset (rst_n low, asynchronous): both stages empty, control registers at their defaults,
// decoding restarts with a packet header expected and one image pixel to go.
module tga_rle_pixel_decoder
    import tga_rle_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            data_byte,

    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [7:0]            red,
    output logic [7:0]            green,
    output logic [7:0]            blue,
    output logic [7:0]            alpha,
    output logic [7:0]            repeat_res,
    output logic                  last_pixel,
    output logic                  overrun
);

    cfg_t        cfg_reg;
    cfg_t        cfg_next;
    logic        cfg_hit;
    dec_state_t  state_reg;
    dec_state_t  state_next;
    dec_state_t  step_state;
    dec_result_t step_result;

    logic        in_valid_reg;
    logic        in_valid_next;
    logic [7:0]  in_byte_reg;

    logic        out_valid_reg;
    logic        out_valid_next;
    dec_result_t out_reg;

    logic        out_free;
    logic        advance;
    logic        in_take;

    assign cfg_ready = 1'b1;

    // Decode configuration writes
    always_comb
    begin
        cfg_next = cfg_reg;
        cfg_hit  = 1'b0;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_BYTES_PER_PIXEL:
                begin
                    cfg_next.bytes_per_pixel = cfg_data[BPP_W-1:0];
                    cfg_hit = 1'b1;
                end
                CFG_COMPRESSED:
                begin
                    cfg_next.compressed = cfg_data[0];
                    cfg_hit = 1'b1;
                end
                CFG_PIXEL_TOTAL:
                begin
                    cfg_next.pixel_total = cfg_data[PIXEL_COUNT_W-1:0];
                    cfg_hit = 1'b1;
                end
                default:
                begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
    end

    // Handshake between the two stages
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        if (in_take)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    always_comb
    begin
        if (advance)
            out_valid_next = step_result.emit;
        else if (out_free)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    tga_rle_step u_step (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .data_byte  (in_byte_reg),
        .state_next (step_state),
        .result     (step_result)
    );

    // Restart on a configuration write, otherwise follow the decoded byte
    always_comb
    begin
        if (cfg_hit)
            state_next = restart_state(cfg_next.pixel_total);
        else if (advance)
            state_next = step_state;
        else
            state_next = state_reg;
    end

    // Control and decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bytes_per_pixel <= BPP_32BIT;
            cfg_reg.compressed      <= 1'b0;
            cfg_reg.pixel_total     <= PIXEL_TOTAL_RESET;
            state_reg               <= restart_state(PIXEL_TOTAL_RESET);
            in_valid_reg            <= 1'b0;
            out_valid_reg           <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            state_reg     <= state_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
            in_byte_reg <= data_byte;
        if (advance)
            out_reg <= step_result;
    end

    assign out_valid  = out_valid_reg;
    assign red        = out_reg.red;
    assign green      = out_reg.green;
    assign blue       = out_reg.blue;
    assign alpha      = out_reg.alpha;
    assign repeat_res = out_reg.repeat_res;
    assign last_pixel = out_reg.last_pixel;
    assign overrun    = out_reg.overrun;

endmodule

@@ rtl/core/tga_rle_chk.sv @@
module tga_rle_chk
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_stall,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic [7:0]            red,
    input  logic [7:0]            green,
    input  logic [7:0]            blue,
    input  logic [7:0]            alpha,
    input  logic [7:0]            repeat_res,
    input  logic                  last_pixel,
    input  logic                  overrun
);

    // Hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(red) && $stable(green)
            && $stable(blue) && $stable(alpha) && $stable(repeat_res)
            && $stable(last_pixel) && $stable(overrun))
        else $error("stalled result changed");

    // Input backs up only behind a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while result side free");

    // A decoded pixel covers 1 to 128 image pixels
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !overrun |-> repeat_res != 8'd0 && repeat_res <= 8'd128)
        else $error("repeat count out of range");

    // A zero repeat marks a surplus byte only
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && repeat_res == 8'd0 |-> overrun && !last_pixel
            && red == 8'd0 && green == 8'd0 && blue == 8'd0 && alpha == 8'd0)
        else $error("malformed surplus result");

endmodule

bind tga_rle_pixel_decoder tga_rle_chk u_tga_rle_chk (.*);

@@ tb/sv/tga_rle_pixel_decoder_tb.sv @@
module tga_rle_pixel_decoder_tb;
    import tga_rle_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CYCLE_LIMIT     = 400_000;
    localparam int          RANDOM_ITEMS    = 900;
    localparam int          SETTLE_CYCLES   = 4;
    localparam logic [1:0]  CFG_SPARE_INDEX = 2'd3;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [7:0] repeat_res;
        logic       last_pixel;
        logic       overrun;
    } decoded_pixel_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [1:0]            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [7:0]            data_byte;
    logic                  out_valid;
    logic                  out_stall;
    logic [7:0]            red;
    logic [7:0]            green;
    logic [7:0]            blue;
    logic [7:0]            alpha;
    logic [7:0]            repeat_res;
    logic                  last_pixel;
    logic                  overrun;

    // Register shadows
    logic [BPP_W-1:0]         bpp_reg;
    logic                     compressed_reg;
    logic [PIXEL_COUNT_W-1:0] total_reg;

    // Decoder state mirror
    int                       byte_pos;
    logic [23:0]              gathered;
    logic                     want_header;
    logic                     in_run;
    logic [7:0]               packet_left;
    logic [PIXEL_COUNT_W-1:0] image_left;

    decoded_pixel_t pixels_due[$];
    int unsigned    mismatch_count;
    int unsigned    bytes_sent;
    int unsigned    in_idle_pct;
    int unsigned    out_idle_pct;

    tga_rle_pixel_decoder uut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Abort a hung run
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("end of test: mismatches");
        $finish;
    end

    function automatic int pixel_width();
        if (bpp_reg < BPP_16BIT) return 2;
        if (bpp_reg > BPP_32BIT) return 4;
        return int'(bpp_reg);
    endfunction

    function automatic void restart_decode();
        byte_pos    = 0;
        gathered    = '0;
        want_header = 1'b1;
        in_run      = 1'b0;
        packet_left = '0;
        image_left  = total_reg;
    endfunction

    function automatic void apply_register(input logic [1:0] idx,
                                           input logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_BYTES_PER_PIXEL: bpp_reg = val[BPP_W-1:0];
            CFG_COMPRESSED:      compressed_reg = val[0];
            CFG_PIXEL_TOTAL:     total_reg = val[PIXEL_COUNT_W-1:0];
            default:             return;
        endcase
        restart_decode();
    endfunction

    // Append a pixel to the expected results
    function automatic void queue_pixel(input decoded_pixel_t px);
        pixels_due = {pixels_due, px};
    endfunction

    // Advance the decoder mirror by one byte and queue the pixel it yields
    function automatic void decode_byte(input logic [7:0] b);
        decoded_pixel_t           px;
        logic [7:0]               lo;
        logic [7:0]               mid;
        logic [7:0]               hi;
        logic [PIXEL_COUNT_W-1:0] run_len;
        px = '0;
        if (image_left == '0)
        begin
            px.overrun = 1'b1;
            queue_pixel(px);
            return;
        end
        if (compressed_reg && want_header)
        begin
            in_run      = b[7];
            packet_left = {1'b0, b[6:0]} + 8'd1;
            want_header = 1'b0;
            byte_pos    = 0;
            gathered    = '0;
            return;
        end
        if (byte_pos + 1 < pixel_width())
        begin
            gathered[8*byte_pos +: 8] = b;
            byte_pos++;
            return;
        end
        lo  = gathered[7:0];
        mid = gathered[15:8];
        hi  = gathered[23:16];
        case (pixel_width())
            BPP_16BIT:
            begin
                px.red   = {b[6:2], 3'b000};
                px.green = {b[1:0], lo[7:5], 3'b000};
                px.blue  = {lo[4:0], 3'b000};
                px.alpha = {b[7], 7'd0};
            end
            BPP_24BIT:
            begin
                px.red   = b;
                px.green = mid;
                px.blue  = lo;
                px.alpha = 8'd0;
            end
            default:
            begin
                px.red   = hi;
                px.green = mid;
                px.blue  = lo;
                px.alpha = b;
            end
        endcase
        byte_pos = 0;
        gathered = '0;
        if (compressed_reg && in_run)
        begin
            // Cut the run at the image end
            run_len = PIXEL_COUNT_W'(packet_left);
            if (run_len > image_left)
            begin
                run_len    = image_left;
                px.overrun = 1'b1;
            end
            packet_left = '0;
            want_header = 1'b1;
        end
        else
        begin
            run_len = PIXEL_COUNT_W'(1);
            if (compressed_reg)
            begin
                packet_left--;
                if (packet_left == '0) want_header = 1'b1;
            end
        end
        image_left    -= run_len;
        px.repeat_res  = run_len[7:0];
        px.last_pixel  = (image_left == '0);
        queue_pixel(px);
    endfunction

    function automatic int draw_wait(input int unsigned pct);
        if ($urandom_range(99) < pct) return $urandom_range(8, 1);
        return 0;
    endfunction

    function automatic int unsigned pick_idle();
        case ($urandom_range(3))
            0:       return 0;
            1:       return 20;
            2:       return 50;
            default: return 100;
        endcase
    endfunction

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    // Send one byte, hold it until taken, then predict
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = draw_wait(in_idle_pct);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        do @(negedge clk); while (in_stall !== 1'b0);
        @(posedge clk);
        bytes_sent++;
        decode_byte(b);
    endtask

    task automatic send_pixel();
        repeat (pixel_width()) send_byte(rand_byte());
    endtask

    // Let queued results drain and the pipeline empty
    task automatic wait_idle();
        while (pixels_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] val);
        in_valid <= 1'b0;
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(negedge clk); while (cfg_ready !== 1'b1);
        @(posedge clk);
        cfg_valid <= 1'b0;
        apply_register(idx, val);
    endtask

    // Check each result against the oldest expected pixel; stall at random
    initial
    begin : result_monitor
        int             hold;
        logic           took;
        decoded_pixel_t want;
        hold = 0;
        forever
        begin
            @(negedge clk);
            took = (out_valid === 1'b1) && (out_stall === 1'b0);
            if (took)
            begin
                if (pixels_due.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: result with none expected, got rgba %0d %0d %0d %0d",
                             $time, red, green, blue, alpha);
                end
                else
                begin
                    want = pixels_due.pop_front();
                    check_field("red", want.red, red);
                    check_field("green", want.green, green);
                    check_field("blue", want.blue, blue);
                    check_field("alpha", want.alpha, alpha);
                    check_field("repeat_res", want.repeat_res, repeat_res);
                    check_field("last_pixel", {7'd0, want.last_pixel}, {7'd0, last_pixel});
                    check_field("overrun", {7'd0, want.overrun}, {7'd0, overrun});
                end
            end
            @(posedge clk);
            if (took) hold = draw_wait(out_idle_pct);
            else if (hold > 0) hold--;
            out_stall <= (hold > 0);
        end
    end

    // Plain pixels at reset settings, then 16-bit with an out-of-range size
    task automatic test_raw_pixels();
        in_idle_pct  = 0;
        out_idle_pct = 0;
        send_byte(8'h01);
        send_byte(8'h80);
        send_byte(8'hFF);
        send_byte(8'h7F);
        write_reg(CFG_BYTES_PER_PIXEL, 0);
        write_reg(CFG_PIXEL_TOTAL, 2);
        send_byte(8'hFF);
        send_byte(8'h7F);
        send_byte(8'h00);
        send_byte(8'h80);
    endtask

    // Runs, raw packets past the image end, a cut run and an empty image
    task automatic test_run_packets();
        in_idle_pct  = 50;
        out_idle_pct = 50;
        write_reg(CFG_BYTES_PER_PIXEL, CFG_DATA_W'(BPP_24BIT));
        write_reg(CFG_COMPRESSED, 1);
        write_reg(CFG_PIXEL_TOTAL, 129);
        send_byte(8'hFF);
        send_byte(8'h10);
        send_byte(8'h20);
        send_byte(8'h30);
        send_byte(8'h01);
        send_byte(8'hAA);
        send_byte(8'h55);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hFF);
        write_reg(CFG_PIXEL_TOTAL, 1);
        send_byte(8'h85);
        send_byte(8'h12);
        send_byte(8'h34);
        send_byte(8'h56);
        write_reg(CFG_PIXEL_TOTAL, 0);
        send_byte(8'h5A);
    endtask

    // A write to the spare index keeps state; a real write restarts mid-pixel
    task automatic test_restart_on_write();
        in_idle_pct  = 30;
        out_idle_pct = 30;
        write_reg(CFG_COMPRESSED, 0);
        write_reg(CFG_BYTES_PER_PIXEL, CFG_DATA_W'(BPP_24BIT));
        write_reg(CFG_PIXEL_TOTAL, 2);
        send_byte(8'h11);
        send_byte(8'h22);
        write_reg(CFG_SPARE_INDEX, '1);
        send_byte(8'h33);
        send_byte(8'h44);
        write_reg(CFG_BYTES_PER_PIXEL, 7);
        send_byte(8'h55);
        send_byte(8'h66);
        send_byte(8'h77);
        send_byte(8'h88);
    endtask

    task automatic send_pixel_stream(input int unsigned budget);
        int unsigned start;
        logic        is_run;
        logic [6:0]  count;
        start = bytes_sent;
        while (bytes_sent - start < budget)
        begin
            if ($urandom_range(9) == 0)
                send_byte(rand_byte());
            else if (compressed_reg)
            begin
                is_run = 1'($urandom_range(1));
                if (is_run)
                    count = 7'(($urandom_range(3) == 0) ? $urandom_range(127)
                                                        : $urandom_range(7));
                else
                    count = 7'($urandom_range(5));
                send_byte({is_run, count});
                if (is_run) send_pixel();
                else repeat (count + 1) send_pixel();
            end
            else
                send_pixel();
        end
    endtask

    // Random settings, each followed by a mostly well-formed byte stream
    task automatic test_random_streams();
        int unsigned         target;
        logic [BPP_W-1:0]    bpp;
        logic [CFG_DATA_W-1:0] total;
        target = bytes_sent + RANDOM_ITEMS;
        while (bytes_sent < target)
        begin
            bpp = BPP_W'(($urandom_range(9) == 0) ? $urandom_range(7)
                                                  : $urandom_range(4, 2));
            case ($urandom_range(15))
                0:       total = '0;
                1:       total = 25'h1FFFFFF;
                2:       total = 25'h1000000;
                3:       total = CFG_DATA_W'($urandom);
                default: total = CFG_DATA_W'($urandom_range(40, 1));
            endcase
            write_reg(CFG_BYTES_PER_PIXEL, CFG_DATA_W'(bpp));
            write_reg(CFG_COMPRESSED, CFG_DATA_W'($urandom_range(1)));
            write_reg(CFG_PIXEL_TOTAL, total);
            in_idle_pct  = pick_idle();
            out_idle_pct = pick_idle();
            send_pixel_stream($urandom_range(40, 10));
        end
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_BYTES_PER_PIXEL;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        data_byte <= '0;
        out_stall <= 1'b0;
        mismatch_count = 0;
        bytes_sent     = 0;
        in_idle_pct    = 0;
        out_idle_pct   = 0;
        bpp_reg        = BPP_32BIT;
        compressed_reg = 1'b0;
        total_reg      = PIXEL_TOTAL_RESET;
        restart_decode();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_raw_pixels();
        test_run_packets();
        test_restart_on_write();
        test_random_streams();

        // Drain and let late results show
        in_valid <= 1'b0;
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
